>>> hw/rtl/cma_pkg.sv
// Shared constants for the centered moving average block.
// No dependencies; every other file of the block imports this package.
package cma_pkg;

    localparam int RING_DEPTH_DEF = 64;  // default sample ring depth
    localparam int INDEX_BITS_DEF = 16;  // default width of the frame index counters
    localparam int SAMPLE_W       = 32;  // Q16.16 sample and average width
    localparam int HW_W           = 5;   // half_width register width
    localparam int POS_W          = 16;  // position field width
    localparam int MAX_OUT        = 32;  // most results one word can release
    localparam int EDGE_CAP       = 32;  // saturation point of the edge counter
    localparam int CNT_W          = 6;   // holds 0 .. MAX_OUT and 0 .. EDGE_CAP
    localparam int DIV_W          = HW_W + 1;  // window length 2*w+1 fits here
    // Widest window is 63 samples, so the exact sum needs 6 extra bits.
    localparam int SUM_W          = SAMPLE_W + DIV_W;

endpackage

>>> hw/rtl/cma_if.sv
// Valid/ready channel interfaces of the centered moving average block.
// Depends on cma_pkg for the payload widths.

interface cma_in_if import cma_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;

    modport source (output valid, output sample, output frame_end, input ready);
    modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface cma_out_if import cma_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] average;
    logic [POS_W-1:0]           position;
    logic                       frame_done;

    modport source (output valid, output average, output position, output frame_done,
                    input ready);
    modport sink   (input valid, input average, input position, input frame_done,
                    output ready);
endinterface

interface cma_cfg_if import cma_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [HW_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/centered_moving_average_top.sv
// Top level of the centered moving average block: sample ring, sequencer and
// a shared adder used for summing, serial division and sign handling.
// Depends on cma_pkg and the channel interfaces in cma_if.sv.

// The block takes one frame of signed Q16.16 sample words, the last one marked
// with frame_end, and returns for each frame index k the mean of samples k-w to
// k+w, where w = min(k, half_width, length-1-k), truncated toward zero. A result
// leaves as soon as its window is complete; the marked word flushes all pending
// results, and the last one carries frame_done. Input words are taken one at a
// time: after a word is accepted the block stays busy until every result it
// releases has been loaded into the output register. Each result takes 2*w+1
// reads of the sample ring through its single registered read port, a drain of
// the read pipeline, 38 steps of a restoring divider and four control states,
// plus any wait while the output register is still held by the sink. Each input
// word also passes through acceptance, the final window check and frame
// bookkeeping. The output register lets the next word be accepted while a
// result still waits.
// The half_width register is written over its own channel, which is always
// ready; it must only be written while the block is idle.
module centered_moving_average_top import cma_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cma_in_if.sink   i_in,
    cma_cfg_if.sink  i_cfg,
    cma_out_if.source o_out
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_EVAL, S_SUM, S_ABS, S_DIV, S_SIGN, S_EMIT, S_DONE
    } t_state;

    // Sample ring: written at the write pointer, read through a registered port.
    logic [SAMPLE_W-1:0] ring [RING_DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;

    t_state                     r_state, n_state;
    logic [HW_W-1:0]            r_h, n_h;
    logic [INDEX_BITS-1:0]      r_seen, n_seen;
    logic [INDEX_BITS-1:0]      r_nxt, n_nxt;
    logic [CNT_W-1:0]           r_edge, n_edge;
    logic [AW-1:0]              r_wp, n_wp;
    logic [AW-1:0]              r_optr, n_optr;
    logic                       r_fin, n_fin;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic [DIV_W-1:0]           r_div, n_div;
    logic                       r_last, n_last;
    logic [AW-1:0]              r_dn, n_dn;
    logic [AW-1:0]              r_up, n_up;
    logic [CNT_W-1:0]           r_ndn, n_ndn;
    logic [HW_W-1:0]            r_nup, n_nup;
    logic                       r_rd_v;
    logic [SUM_W-1:0]           r_acc, n_acc;
    logic [DIV_W-1:0]           r_rem, n_rem;
    logic [CNT_W-1:0]           r_bits, n_bits;
    logic                       r_neg, n_neg;
    logic                       r_out_valid, n_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_avg, n_out_avg;
    logic [POS_W-1:0]           r_out_pos, n_out_pos;
    logic                       r_out_done, n_out_done;

    // The one shared adder.
    logic [SUM_W-1:0] alu_a, alu_b, alu_sum;
    logic             alu_cin;

    // Window decision terms.
    logic [INDEX_BITS-1:0] pending, lag;
    logic [HW_W-1:0]       lw, w_sel;
    logic                  lag_lt_lw, stop;
    logic                  issue;
    logic [DIV_W:0]        rem_sh;
    logic                  trial_ok;
    logic                  in_acc, out_free;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
        return (a == '0) ? LAST_ADDR : a - 1'b1;
    endfunction

    assign in_acc       = i_in.valid && i_in.ready;
    assign i_in.ready   = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign out_free     = !r_out_valid || o_out.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.average    = r_out_avg;
    assign o_out.position   = r_out_pos;
    assign o_out.frame_done = r_out_done;

    assign pending   = r_seen - r_nxt;
    assign lag       = pending - 1'b1;
    assign lw        = (r_edge < CNT_W'(r_h)) ? r_edge[HW_W-1:0] : r_h;
    assign lag_lt_lw = lag < INDEX_BITS'(lw);
    assign w_sel     = (r_fin && lag_lt_lw) ? lag[HW_W-1:0] : lw;
    assign stop      = (pending == '0) || (r_cnt == CNT_W'(MAX_OUT))
                       || (!r_fin && lag_lt_lw);

    assign issue  = (r_ndn != '0) || (r_nup != '0);
    assign rem_sh = {r_rem, r_acc[SUM_W-1]};

    always_comb begin
        alu_a   = r_acc;
        alu_b   = '0;
        alu_cin = 1'b0;
        case (r_state)
            S_SUM: begin
                alu_b = SUM_W'(signed'(r_rdata));
            end
            S_DIV: begin
                alu_a   = SUM_W'(rem_sh);
                alu_b   = ~SUM_W'(r_div);
                alu_cin = 1'b1;
            end
            S_ABS, S_SIGN: begin
                alu_a   = ~r_acc;
                alu_cin = 1'b1;
            end
            default: begin
                alu_cin = 1'b0;
            end
        endcase
    end

    assign alu_sum  = alu_a + alu_b + SUM_W'(alu_cin);
    assign trial_ok = !alu_sum[SUM_W-1];

    always_comb begin
        rd_en   = (r_state == S_SUM) && issue;
        rd_addr = (r_ndn != '0) ? r_dn : r_up;
        wr_en   = in_acc;
    end

    always_comb begin
        n_state     = r_state;
        n_h         = r_h;
        n_seen      = r_seen;
        n_nxt       = r_nxt;
        n_edge      = r_edge;
        n_wp        = r_wp;
        n_optr      = r_optr;
        n_fin       = r_fin;
        n_cnt       = r_cnt;
        n_div       = r_div;
        n_last      = r_last;
        n_dn        = r_dn;
        n_up        = r_up;
        n_ndn       = r_ndn;
        n_nup       = r_nup;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_bits      = r_bits;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_avg   = r_out_avg;
        n_out_pos   = r_out_pos;
        n_out_done  = r_out_done;

        if (i_cfg.valid) begin
            n_h = i_cfg.data;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_wp    = wrap_inc(r_wp);
                    n_seen  = r_seen + 1'b1;
                    n_fin   = i_in.frame_end;
                    n_cnt   = '0;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (stop) begin
                    n_state = S_DONE;
                end else begin
                    n_div   = {w_sel, 1'b1};
                    n_ndn   = CNT_W'(w_sel) + 1'b1;
                    n_nup   = w_sel;
                    n_dn    = r_optr;
                    n_up    = wrap_inc(r_optr);
                    n_acc   = '0;
                    n_last  = r_fin && ((lag == '0) || (r_cnt == CNT_W'(MAX_OUT - 1)));
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                // Older half of the window first, walking down from sample k.
                if (r_ndn != '0) begin
                    n_dn  = wrap_dec(r_dn);
                    n_ndn = r_ndn - 1'b1;
                end else if (r_nup != '0) begin
                    n_up  = wrap_inc(r_up);
                    n_nup = r_nup - 1'b1;
                end
                if (r_rd_v) begin
                    n_acc = alu_sum;
                end
                if (!issue && !r_rd_v) begin
                    n_state = S_ABS;
                end
            end
            S_ABS: begin
                n_neg = r_acc[SUM_W-1];
                if (r_acc[SUM_W-1]) begin
                    n_acc = alu_sum;
                end
                n_rem   = '0;
                n_bits  = CNT_W'(SUM_W);
                n_state = S_DIV;
            end
            S_DIV: begin
                // One restoring step: the quotient bit shifts in as the dividend leaves.
                n_rem  = trial_ok ? alu_sum[DIV_W-1:0] : rem_sh[DIV_W-1:0];
                n_acc  = {r_acc[SUM_W-2:0], trial_ok};
                n_bits = r_bits - 1'b1;
                if (r_bits == CNT_W'(1)) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                if (r_neg) begin
                    n_acc = alu_sum;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_avg   = signed'(r_acc[SAMPLE_W-1:0]);
                    n_out_pos   = POS_W'(r_nxt);
                    n_out_done  = r_last;
                    n_nxt       = r_nxt + 1'b1;
                    n_edge      = (r_edge < CNT_W'(EDGE_CAP)) ? r_edge + 1'b1 : r_edge;
                    n_cnt       = r_cnt + 1'b1;
                    n_optr      = wrap_inc(r_optr);
                    n_state     = S_EVAL;
                end
            end
            S_DONE: begin
                if (r_fin) begin
                    n_seen = '0;
                    n_nxt  = '0;
                    n_edge = '0;
                    n_optr = r_wp;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            ring[r_wp] <= i_in.sample;
        end
        if (rd_en) begin
            r_rdata <= ring[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_div      <= n_div;
        r_last     <= n_last;
        r_dn       <= n_dn;
        r_up       <= n_up;
        r_acc      <= n_acc;
        r_rem      <= n_rem;
        r_bits     <= n_bits;
        r_neg      <= n_neg;
        r_out_avg  <= n_out_avg;
        r_out_pos  <= n_out_pos;
        r_out_done <= n_out_done;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_h         <= '0;
            r_seen      <= '0;
            r_nxt       <= '0;
            r_edge      <= '0;
            r_wp        <= '0;
            r_optr      <= '0;
            r_fin       <= 1'b0;
            r_cnt       <= '0;
            r_ndn       <= '0;
            r_nup       <= '0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_h         <= n_h;
            r_seen      <= n_seen;
            r_nxt       <= n_nxt;
            r_edge      <= n_edge;
            r_wp        <= n_wp;
            r_optr      <= n_optr;
            r_fin       <= n_fin;
            r_cnt       <= n_cnt;
            r_ndn       <= n_ndn;
            r_nup       <= n_nup;
            r_rd_v      <= rd_en;
            r_out_valid <= n_out_valid;
        end
    end

    // One word never releases more results than the pending limit.
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_OUT))
        else $error("result count passed the pending limit");

    // Read data only arrives for reads issued while summing.
    a_rd_in_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_v |-> (r_state == S_SUM && $past(r_state) == S_SUM))
        else $error("ring read data outside the summing phase");

    // The divider works on an odd window length and keeps the remainder below it.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div[0] && r_rem < r_div))
        else $error("divider remainder or window length out of range");

    // A frame-done result can only come from a marked last word.
    a_done_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_last) |-> r_fin)
        else $error("frame_done without a frame_end word");

endmodule

>>> tb/tb_centered_moving_average_top.sv
// Self-checking testbench for centered_moving_average_top: drives sample frames,
// predicts every window mean and compares each output word against it.
// Depends on cma_pkg, the channel interfaces in cma_if.sv and the block's RTL.
module tb_centered_moving_average_top import cma_pkg::*; ();

    localparam int N_WORDS        = 256;   // random word budget after the table
    localparam int SETTLE_CYCLES  = 150;
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic [POS_W-1:0]           position;
        logic                       frame_done;
    } t_avg_result;

    typedef enum logic [1:0] {ROW_SET_HW, ROW_WORD, ROW_WORD_TYPED} t_row_kind;

    typedef struct packed {
        t_row_kind                  kind;
        logic [HW_W-1:0]            hw;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       fin;
        t_avg_result                want;
    } t_stim_row;

    localparam t_avg_result NO_RESULT = '0;
    localparam int N_ROWS = 27;

    // Single-sample frames average to the sample itself, so their results are
    // typed in; longer frames are left to the predictor.
    t_stim_row directed_rows [N_ROWS] = '{
        '{ROW_WORD_TYPED, 5'd0,  32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 16'd0, 1'b1}},
        '{ROW_WORD_TYPED, 5'd0,  32'h8000_0000, 1'b1, '{32'h8000_0000, 16'd0, 1'b1}},
        '{ROW_SET_HW,     5'd31, 32'h0000_0000, 1'b0, NO_RESULT},
        '{ROW_WORD_TYPED, 5'd0,  32'h0000_0000, 1'b1, '{32'h0000_0000, 16'd0, 1'b1}},
        '{ROW_WORD_TYPED, 5'd0,  32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 16'd0, 1'b1}},
        '{ROW_WORD,       5'd0,  32'h7FFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_WORD,       5'd0,  32'h7FFF_FFFF, 1'b1, NO_RESULT},
        '{ROW_WORD,       5'd0,  32'h7FFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_WORD,       5'd0,  32'h7FFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_WORD,       5'd0,  32'h7FFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_WORD,       5'd0,  32'h8000_0000, 1'b0, NO_RESULT},
        '{ROW_WORD,       5'd0,  32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_WORD,       5'd0,  32'h0000_0001, 1'b0, NO_RESULT},
        '{ROW_WORD,       5'd0,  32'h1234_5678, 1'b1, NO_RESULT},
        '{ROW_SET_HW,     5'd2,  32'h0000_0000, 1'b0, NO_RESULT},
        '{ROW_WORD,       5'd0,  32'hFFFF_FFF9, 1'b0, NO_RESULT},
        '{ROW_WORD,       5'd0,  32'h0000_0003, 1'b0, NO_RESULT},
        '{ROW_WORD,       5'd0,  32'hFFFF_FFFE, 1'b0, NO_RESULT},
        '{ROW_WORD,       5'd0,  32'h0000_0005, 1'b0, NO_RESULT},
        '{ROW_WORD,       5'd0,  32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_WORD,       5'd0,  32'h8000_0000, 1'b0, NO_RESULT},
        '{ROW_WORD,       5'd0,  32'h7FFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_WORD,       5'd0,  32'hFFFF_FFFD, 1'b0, NO_RESULT},
        '{ROW_WORD,       5'd0,  32'h0000_0004, 1'b1, NO_RESULT},
        '{ROW_SET_HW,     5'd0,  32'h0000_0000, 1'b0, NO_RESULT},
        '{ROW_WORD,       5'd0,  32'h0000_0005, 1'b0, NO_RESULT},
        '{ROW_WORD,       5'd0,  32'hFFFF_FFFB, 1'b1, NO_RESULT}
    };

    logic i_clk;
    logic i_rst_n;

    cma_in_if  in_bus  ();
    cma_cfg_if cfg_bus ();
    cma_out_if out_bus ();

    centered_moving_average_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .i_cfg   (cfg_bus),
        .o_out   (out_bus)
    );

    // Predictor state.
    logic signed [SAMPLE_W-1:0] sample_hist [RING_DEPTH_DEF];
    int unsigned                hist_wr     = 0;
    logic [INDEX_BITS_DEF-1:0]  taken_cnt   = '0;
    logic [INDEX_BITS_DEF-1:0]  emitted_cnt = '0;
    int unsigned                edge_run    = 0;
    logic [HW_W-1:0]            model_hw    = '0;
    t_avg_result                owed_averages [$];

    // Handoff from the driver to the monitor for words with a typed result.
    bit          word_is_typed = 1'b0;
    t_avg_result typed_result  = '0;

    bit calm = 1'b0;  // no idling on either side while set
    int n_errors = 0, n_words = 0, n_frames = 0, n_checked = 0, n_hw_writes = 0;
    int quiet_cycles = 0;

    // Stores one sample and releases every mean whose window is now complete;
    // a marked word flushes the rest with the window shrunk to the frame end.
    function automatic void predict_averages(input logic signed [SAMPLE_W-1:0] smp,
                                             input logic fin, input bit keep);
        logic [INDEX_BITS_DEF-1:0] waiting;
        int unsigned lag, lim, span, off;
        longint acc;
        t_avg_result r;
        t_avg_result batch [$];
        sample_hist[hist_wr] = smp;
        hist_wr = (hist_wr + 1) % RING_DEPTH_DEF;
        taken_cnt = taken_cnt + 1'b1;
        while (batch.size() < MAX_OUT) begin
            waiting = taken_cnt - emitted_cnt;
            if (waiting == 0) break;
            lag = waiting - 1;
            lim = (edge_run < model_hw) ? edge_run : model_hw;
            if (fin) begin
                span = (lim < lag) ? lim : lag;
            end else if (lim > lag) begin
                break;
            end else begin
                span = lim;
            end
            acc = 0;
            for (int i = 0; i <= 2 * span; i++) begin
                // Offset 0 is the newest sample.
                off = (lag + span - i) % RING_DEPTH_DEF;
                acc += longint'(sample_hist[(hist_wr + RING_DEPTH_DEF - 1 - off)
                                            % RING_DEPTH_DEF]);
            end
            r.average    = acc / longint'(2 * span + 1);
            r.position   = emitted_cnt[POS_W-1:0];
            r.frame_done = 1'b0;
            batch.push_back(r);
            emitted_cnt = emitted_cnt + 1'b1;
            if (edge_run < EDGE_CAP) edge_run++;
        end
        if (fin) begin
            if (batch.size() > 0) begin
                r = batch[batch.size()-1];
                r.frame_done = 1'b1;
                batch[batch.size()-1] = r;
            end
            taken_cnt   = '0;
            emitted_cnt = '0;
            edge_run    = 0;
        end
        if (keep) begin
            foreach (batch[k]) owed_averages.push_back(batch[k]);
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Output side: holds ready low about 8 percent of the time unless calm.
    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_bus.ready <= calm || ($urandom_range(99) >= 8);
        end
    end

    // Monitor: every handshake is seen here, at the rising edge.
    always @(posedge i_clk) begin : monitor
        t_avg_result got, want;
        if (i_rst_n) begin
            quiet_cycles++;
            if (out_bus.valid && out_bus.ready) begin
                quiet_cycles = 0;
                got = '{out_bus.average, out_bus.position, out_bus.frame_done};
                if (owed_averages.size() == 0) begin
                    $display("%0t: unexpected result: average %h position %0d done %0b",
                             $time, got.average, got.position, got.frame_done);
                    n_errors++;
                end else begin
                    want = owed_averages.pop_front();
                    n_checked++;
                    if (got.average !== want.average) begin
                        $display("%0t: average mismatch: expected %h, actual %h",
                                 $time, want.average, got.average);
                        n_errors++;
                    end
                    if (got.position !== want.position) begin
                        $display("%0t: position mismatch: expected %0d, actual %0d",
                                 $time, want.position, got.position);
                        n_errors++;
                    end
                    if (got.frame_done !== want.frame_done) begin
                        $display({"%0t: frame_done mismatch at position %0d: ",
                                  "expected %0b, actual %0b"},
                                 $time, want.position, want.frame_done, got.frame_done);
                        n_errors++;
                    end
                end
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                quiet_cycles = 0;
                model_hw = cfg_bus.data;
                n_hw_writes++;
            end
            if (in_bus.valid && in_bus.ready) begin
                quiet_cycles = 0;
                predict_averages(in_bus.sample, in_bus.frame_end, !word_is_typed);
                if (word_is_typed) owed_averages.push_back(typed_result);
                n_words++;
                if (in_bus.frame_end) n_frames++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results still owed",
                         $time, quiet_cycles, owed_averages.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_word(input logic signed [SAMPLE_W-1:0] smp, input logic fin,
                             input bit typed, input t_avg_result want);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 8) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        word_is_typed = typed;
        typed_result  = want;
        in_bus.valid     <= 1'b1;
        in_bus.sample    <= smp;
        in_bus.frame_end <= fin;
        do @(posedge i_clk); while (!in_bus.ready);
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
    endtask

    // Waits until every owed result is in, then lets the block finish any
    // bookkeeping for words that released nothing.
    task automatic settle();
        while (owed_averages.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_half_width(input logic [HW_W-1:0] hw);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= hw;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin : stimulus
        int sent, frame_no, len, change_at;
        logic [HW_W-1:0] hw;
        logic signed [SAMPLE_W-1:0] smp;

        i_rst_n           = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.sample     = '0;
        in_bus.frame_end  = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.data      = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            case (directed_rows[r].kind)
                ROW_SET_HW: begin
                    settle();
                    write_half_width(directed_rows[r].hw);
                end
                ROW_WORD: begin
                    send_word(directed_rows[r].sample, directed_rows[r].fin, 1'b0, NO_RESULT);
                end
                default: begin
                    send_word(directed_rows[r].sample, directed_rows[r].fin, 1'b1,
                              directed_rows[r].want);
                end
            endcase
        end

        // Random frames. The first is long enough to wrap the sample ring.
        sent = 0;
        frame_no = 0;
        while (sent < N_WORDS) begin
            if (frame_no == 0 || $urandom_range(2) == 0) begin
                case ($urandom_range(3))
                    0: hw = '0;
                    1: hw = '1;
                    default: hw = $urandom_range(31);
                endcase
                settle();
                write_half_width(hw);
            end
            case ($urandom_range(9))
                0: len = 1;
                1: len = $urandom_range(2, 4);
                2: len = $urandom_range(65, 100);
                default: len = $urandom_range(5, 30);
            endcase
            if (frame_no == 0) len = 100;
            // The last frame is cut to what is left of the word budget.
            if (len > N_WORDS - sent) len = N_WORDS - sent;
            // Now and then the window width changes partway through a frame.
            change_at = (len > 8 && $urandom_range(4) == 0) ? $urandom_range(1, len - 2) : 0;
            for (int k = 0; k < len; k++) begin
                calm = (sent >= 130 && sent < 190);
                case ($urandom_range(3))
                    2: smp = $urandom_range(400) - 200;
                    3: begin
                        smp = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                        if ($urandom_range(1)) smp = smp ^ $urandom_range(255);
                    end
                    default: smp = $urandom;
                endcase
                send_word(smp, k == len - 1, 1'b0, NO_RESULT);
                sent++;
                if (k + 1 == change_at) begin
                    settle();
                    write_half_width($urandom_range(31));
                end
            end
            frame_no++;
        end
        calm = 1'b0;

        settle();
        if (owed_averages.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, owed_averages.size());
            n_errors++;
        end
        $display("Ran %0d sample words in %0d frames with %0d half-width writes;",
                 n_words, n_frames, n_hw_writes);
        $display("%0d window means compared, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
